// ===== src/sps_pkg.sv =====
// Shared types and constants for the servo pulse sequencer.
package sps_pkg;

  localparam int unsigned MaxSlots = 16;
  localparam logic [12:0] WidthRst = 13'd800;
  localparam logic [12:0] AngleBase = 13'd800;
  localparam logic [7:0] AngleMax = 8'd180;
  // angle * ConvRecip >> 18 gives (190 * angle) / 18 for angles up to 180
  localparam logic [21:0] ConvRecip = 22'd2767160;
  // x * RepRecip >> 17 gives x / 21 for x below 8192
  localparam logic [12:0] RepRecip = 13'd6242;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_MOVEI = 2'd1,
    OP_MOVED = 2'd2,
    OP_PLACE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_COUNT   = 2'd0,
    REG_MINUS   = 2'd1,
    REG_REFRESH = 2'd2,
    REG_OFFSET  = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_MOVE,
    ST_STEP_DIV,
    ST_STEP_DONE,
    ST_MATCH,
    ST_REPORT,
    ST_OUT
  } state_t;

  // divider control between sequencer and shared unit
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

// ===== src/sps_div.sv =====
// Shared restoring divider, one quotient bit a cycle.
module sps_div (
  input  logic            clk,
  input  logic            rst,
  input  sps_pkg::div_req_t req,
  output sps_pkg::div_rsp_t rsp
);
  import sps_pkg::*;

  logic [15:0] quo;
  logic [8:0]  rem;
  logic [8:0]  dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [9:0]  trial;

  assign trial = {rem, quo[15]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!trial[9]) begin
          rem <= trial[8:0];
          quo <= {quo[14:0], 1'b1};
        end else begin
          rem <= {rem[7:0], quo[15]};
          quo <= {quo[14:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

// ===== src/servo_pulse_sequencer_ramped.sv =====
// Top level of the servo pulse sequencer with ramped moves.
//
// channel  dir  handshake         payload
// s_axis   in   tvalid/tready     tdata: operation, servo_index, angle, speed
// m_axis   out  tvalid/tready     tdata: pulse_lines, move_result, servo_moving, servo_angle
// cfg      in   cfg_valid/ready   cfg_index, cfg_data
//
// A tick passes through ST_MATCH, ST_REPORT and ST_OUT before its result shows; a move or place
// passes through ST_CONV, ST_MOVE, ST_STEP_DIV (waiting on the shared 16-step divider that
// forms the ramp step), ST_STEP_DONE, ST_REPORT and ST_OUT. One item at a time; the result
// register holds until taken, and the next item is accepted the cycle after.
// Reset is synchronous and restores all slot state at once.
module servo_pulse_sequencer_ramped #(
  parameter int unsigned SERVO_SLOTS = sps_pkg::MaxSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // operation[1:0], servo_index[5:2], angle[13:6], speed[21:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pulse_lines[15:0], move_result[16], servo_moving[17],
                                      // servo_angle[25:18]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sps_pkg::*;

  localparam int unsigned SW = (SERVO_SLOTS > 1) ? $clog2(SERVO_SLOTS) : 1;

  logic [4:0]  servo_count;
  logic [9:0]  min_pulse_us;
  logic [15:0] frame_period;
  logic [15:0] refresh_offset;

  logic [15:0] timer_count;
  logic [15:0] compare_value;
  logic        in_frame;
  logic [4:0]  current_slot;
  logic [12:0] pulse_width [SERVO_SLOTS];
  logic [12:0] target_width [SERVO_SLOTS];
  logic [12:0] ramp_step [SERVO_SLOTS];
  logic [SERVO_SLOTS-1:0] moving_flags;
  logic [15:0] line_levels;

  state_t state, state_next;
  op_t    op;
  logic [3:0]  idx;
  logic [7:0]  angle;
  logic [7:0]  speed;
  logic        result;
  logic        step_load;
  logic [12:0] tw;
  logic [31:0] out_data;
  logic        out_valid;

  div_req_t dreq;
  div_rsp_t drsp;

  logic [4:0]  used;
  logic        idx_used;
  logic        idx_real;
  logic [SW-1:0] si;
  logic [12:0] pw_i;
  logic [12:0] diff;
  logic [7:0]  ang_sat;
  logic [29:0] conv_prod;
  logic [12:0] tw_calc;
  logic [12:0] rep_w;
  logic [12:0] rep_x;
  logic [25:0] rep_prod;
  logic [8:0]  rep_q;
  logic [7:0]  rep_ang;
  logic        rep_mv;

  sps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign used = (servo_count > 5'(SERVO_SLOTS)) ? 5'(SERVO_SLOTS) : servo_count;
  assign idx_used = {1'b0, idx} < used;
  assign idx_real = {1'b0, idx} < 5'(SERVO_SLOTS);
  assign si = SW'(idx);
  assign pw_i = pulse_width[si];
  assign diff = (pw_i < tw) ? tw - pw_i : pw_i - tw;
  assign ang_sat = (s_axis_tdata[13:6] > AngleMax) ? AngleMax : s_axis_tdata[13:6];
  assign conv_prod = 30'(angle) * 30'(ConvRecip);
  assign tw_calc = 13'((16'(conv_prod[28:18]) + 16'(min_pulse_us)) << 1);
  assign rep_w = idx_real ? pw_i : '0;
  assign rep_x = (rep_w >= AngleBase) ? rep_w - AngleBase : 13'd0;
  assign rep_prod = 26'(rep_x) * 26'(RepRecip);
  assign rep_q = rep_prod[25:17];
  assign rep_ang = (rep_q > 9'd255) ? 8'd255 : rep_q[7:0];
  assign rep_mv = idx_real ? moving_flags[si] : 1'b0;

  assign s_axis_tready = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_count <= 5'd0;
      min_pulse_us <= 10'd400;
      frame_period <= 16'd40000;
      refresh_offset <= 16'd4;
    end else if (cfg_valid) begin
      unique case (reg_t'(cfg_index))
        REG_COUNT:   servo_count <= cfg_data[4:0];
        REG_MINUS:   min_pulse_us <= cfg_data[9:0];
        REG_REFRESH: frame_period <= cfg_data;
        REG_OFFSET:  refresh_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
        if (op_t'(s_axis_tdata[1:0]) == OP_TICK) state_next = ST_MATCH;
        else state_next = ST_CONV;
      end
      ST_CONV:       state_next = ST_MOVE;
      ST_MOVE:       state_next = ST_STEP_DIV;
      ST_STEP_DIV:   if (drsp.done) state_next = ST_STEP_DONE;
      ST_STEP_DONE:  state_next = ST_REPORT;
      ST_MATCH:      state_next = ST_REPORT;
      ST_REPORT:     state_next = ST_OUT;
      ST_OUT:        state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dreq = '0;
    unique case (state)
      ST_MOVE: begin
        dreq.start = 1'b1;
        dreq.dividend = 16'(diff);
        dreq.divisor = 9'(speed) + 9'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      timer_count <= '0;
      compare_value <= '0;
      in_frame <= 1'b0;
      current_slot <= '0;
      moving_flags <= '0;
      line_levels <= '0;
      for (int i = 0; i < SERVO_SLOTS; i++) begin
        pulse_width[i] <= WidthRst;
        target_width[i] <= WidthRst;
        ramp_step[i] <= 13'd1;
      end
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          op <= op_t'(s_axis_tdata[1:0]);
          idx <= s_axis_tdata[5:2];
          angle <= ang_sat;
          speed <= s_axis_tdata[21:14];
          result <= 1'b0;
        end
        ST_CONV: tw <= tw_calc;
        ST_MOVE: begin
          step_load <= idx_used && op != OP_PLACE &&
                       (op == OP_MOVED || !moving_flags[si]) && tw != pw_i;
          if (idx_used) begin
            if (op == OP_PLACE) begin
              pulse_width[si] <= tw;
              target_width[si] <= tw;
              moving_flags[si] <= 1'b0;
            end else if (op == OP_MOVED || !moving_flags[si]) begin
              target_width[si] <= tw;
              if (tw == pw_i) result <= 1'b1;
              else moving_flags[si] <= 1'b1;
            end
          end
        end
        ST_STEP_DONE: begin
          if (step_load) begin
            ramp_step[si] <= (drsp.quotient == 16'd0) ? 13'd1 : 13'(drsp.quotient);
          end
        end
        ST_MATCH: begin
          if (timer_count == compare_value) begin : match
            logic [15:0] t;
            logic [4:0]  ns;
            logic [SW-1:0] k;
            logic [12:0] p, g, st;
            logic [15:0] ln;
            t = in_frame ? timer_count : 16'd0;
            ns = in_frame ? current_slot + 5'd1 : 5'd0;
            k = SW'(ns);
            ln = line_levels;
            if (in_frame && current_slot < 5'(SERVO_SLOTS))
              ln[current_slot[3:0]] = 1'b0;
            if (ns < used) begin
              p = pulse_width[k];
              g = target_width[k];
              st = ramp_step[k];
              compare_value <= t + 16'(p);
              ln[ns[3:0]] = 1'b1;
              in_frame <= 1'b1;
              current_slot <= ns;
              if (moving_flags[k]) begin
                if (p < g) begin
                  if (g - p <= st) begin
                    pulse_width[k] <= g;
                    moving_flags[k] <= 1'b0;
                  end else pulse_width[k] <= p + st;
                end else begin
                  if (p - g <= st) begin
                    pulse_width[k] <= g;
                    moving_flags[k] <= 1'b0;
                  end else pulse_width[k] <= p - st;
                end
              end
            end else begin
              in_frame <= 1'b0;
              current_slot <= '0;
              if ({1'b0, t} < {1'b0, frame_period} + {1'b0, refresh_offset})
                compare_value <= frame_period;
              else
                compare_value <= t + refresh_offset;
            end
            line_levels <= ln;
            timer_count <= t + 16'd1;
          end else begin
            timer_count <= timer_count + 16'd1;
          end
        end
        ST_REPORT: out_data <= {6'd0, rep_ang, rep_mv, result, line_levels};
        ST_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

// ===== src/sps_checker.sv =====
// Port checker for the servo pulse sequencer, bound to the top level.
module sps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_nready_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input taken while result pending");
  a_accept_gap: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back to back accept");
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result too early");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[31:26] == 6'd0)
    else $error("padding bits set");
endmodule

bind servo_pulse_sequencer_ramped sps_checker u_sps_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== bench/tb.sv =====
// Self-checking testbench for the servo pulse sequencer: directed and random items.
`timescale 1ns / 100ps

module tb;
  import sps_pkg::*;

  typedef struct packed {
    logic [15:0] lines;
    logic        at_target;
    logic        moving;
    logic [7:0]  angle;
  } servo_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  servo_pulse_sequencer_ramped DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [4:0]  slots_used_reg;
  logic [9:0]  min_us;
  logic [15:0] frame_len;
  logic [15:0] gap_min;
  logic [15:0] timer;
  logic [15:0] compare;
  int          slot;
  logic [12:0] width [16];
  logic [12:0] target [16];
  logic [12:0] step [16];
  logic        moving [16];
  logic [15:0] lines;

  servo_report_t reports [$];
  int mismatches = 0;
  longint cycles = 0;

  function automatic int used_slots();
    return slots_used_reg > 16 ? 16 : int'(slots_used_reg);
  endfunction

  function automatic logic [12:0] width_of(logic [7:0] a);
    int x;
    x = a > 180 ? 180 : a;
    return 13'(((190 * x) / 18 + min_us) * 2);
  endfunction

  task automatic ramp_slot(int s);
    int p, t, st;
    p = width[s]; t = target[s]; st = step[s];
    if (p < t) begin
      if (t - p <= st) begin p = t; moving[s] = 1'b0; end else p = p + st;
    end else begin
      if (p - t <= st) begin p = t; moving[s] = 1'b0; end else p = p - st;
    end
    width[s] = 13'(p);
  endtask

  task automatic match_compare();
    if (slot < 0) timer = '0;
    else lines[slot] = 1'b0;
    slot++;
    if (slot < used_slots()) begin
      compare = timer + 16'(width[slot]);
      lines[slot] = 1'b1;
      if (moving[slot]) ramp_slot(slot);
    end else begin
      if (17'(timer) < 17'(frame_len) + 17'(gap_min)) compare = frame_len;
      else compare = timer + gap_min;
      slot = -1;
    end
  endtask

  function automatic logic move_servo(int s, logic [7:0] a, logic [7:0] spd);
    logic [12:0] t;
    int d, st;
    t = width_of(a);
    target[s] = t;
    if (t == width[s]) return 1'b1;
    moving[s] = 1'b1;
    d = t > width[s] ? t - width[s] : width[s] - t;
    st = d / (1 + spd);
    if (st == 0) st = 1;
    step[s] = 13'(st);
    return 1'b0;
  endfunction

  task automatic predict_item(op_t op, logic [3:0] idx, logic [7:0] a, logic [7:0] spd);
    servo_report_t r;
    int ang;
    r = '0;
    if (op == OP_TICK) begin
      if (timer == compare) match_compare();
      timer++;
    end else if (idx < used_slots()) begin
      case (op)
        OP_MOVEI: if (!moving[idx]) r.at_target = move_servo(idx, a, spd);
        OP_MOVED: r.at_target = move_servo(idx, a, spd);
        default: begin
          width[idx] = width_of(a);
          target[idx] = width[idx];
          moving[idx] = 1'b0;
        end
      endcase
    end
    r.moving = moving[idx];
    if (width[idx] >= 800) begin
      ang = (width[idx] - 800) / 21;
      r.angle = ang > 255 ? 8'd255 : 8'(ang);
    end
    r.lines = lines;
    reports.push_back(r);
  endtask

  task automatic reset_predictor();
    slots_used_reg = 0; min_us = 400; frame_len = 40000; gap_min = 4;
    timer = 0; compare = 0; slot = -1; lines = 0;
    for (int i = 0; i < 16; i++) begin
      width[i] = 800; target[i] = 800; step[i] = 1; moving[i] = 1'b0;
    end
  endtask

  task automatic send_item(op_t op, logic [3:0] idx, logic [7:0] a, logic [7:0] spd);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, spd, a, idx, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_item(op, idx, a, spd);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_burst_item(op_t op, logic [3:0] idx, logic [7:0] a, logic [7:0] spd);
    send_item(op, idx, a, spd);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  task automatic drain();
    while (reports.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(reg_t r, logic [15:0] v);
    cfg_valid <= 1'b1; cfg_index <= r; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (r)
      REG_COUNT:   slots_used_reg = v[4:0];
      REG_MINUS:   min_us = v[9:0];
      REG_REFRESH: frame_len = v;
      default:     gap_min = v;
    endcase
    @(posedge clk);
  endtask

  task automatic test_directed();
    write_reg(REG_COUNT, 16'd16);
    write_reg(REG_MINUS, 16'd1000);
    write_reg(REG_REFRESH, 16'hFFFF);
    write_reg(REG_OFFSET, 16'hFFFF);
    send_item(OP_TICK, 4'd0, 8'd0, 8'd0);
    send_item(OP_MOVED, 4'd0, 8'd255, 8'd255);
    send_item(OP_MOVEI, 4'd0, 8'd0, 8'd0);
    send_item(OP_MOVEI, 4'd1, 8'd180, 8'd0);
    send_item(OP_PLACE, 4'd2, 8'd90, 8'd7);
    send_item(OP_MOVED, 4'd2, 8'd90, 8'd3);
    send_item(OP_MOVED, 4'd15, 8'd1, 8'd1);
    drain();
    write_reg(REG_COUNT, 16'd3);
    send_item(OP_MOVED, 4'd3, 8'd45, 8'd0);
    send_item(OP_PLACE, 4'd15, 8'd170, 8'd0);
    drain();
    write_reg(REG_MINUS, 16'd0);
    write_reg(REG_REFRESH, 16'd0);
    write_reg(REG_OFFSET, 16'd0);
    send_item(OP_PLACE, 4'd0, 8'd0, 8'd0);
    repeat (12) send_item(OP_TICK, 4'hF, 8'hFF, 8'hFF);
    drain();
  endtask

  task automatic test_random(int n, logic [4:0] cnt, logic [9:0] mn, logic [15:0] rf,
                             logic [15:0] of);
    op_t op;
    write_reg(REG_COUNT, 16'(cnt));
    write_reg(REG_MINUS, 16'(mn));
    write_reg(REG_REFRESH, rf);
    write_reg(REG_OFFSET, of);
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 9) < 7 ? OP_TICK : op_t'($urandom_range(1, 3));
      send_burst_item(op, 4'($urandom), 8'($urandom), 8'($urandom_range(0, 9) < 3 ?
                      $urandom_range(0, 3) : $urandom));
      if (i == n / 2) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin
    servo_report_t got, want;
    cycles++;
    if (cycles > 2000000) begin
      $display("Mismatches found");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[17], m_axis_tdata[25:18]};
      if (reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %h actual %h", want, got);
        end
      end
    end
    if (cycles % 64 < 12) m_axis_tready <= 1'b1;
    else m_axis_tready <= $urandom_range(0, 3) != 0;
  end

  initial begin
    reset_predictor();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(650, 5'd16, 10'd400, 16'd300, 16'd4);
    test_random(650, 5'd4, 10'd0, 16'd1000, 16'd0);
    test_random(650, 5'd31, 10'd1000, 16'd200, 16'd65535);
    if (reports.size() != 0) mismatches++;
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
